@@ rtl/bcl_pkg.sv @@
// Shared types and constants of the bridge command line parser.
// No dependencies; every other file of the block imports this package.
package bcl_pkg;

    localparam int MAX_DATA_BYTES = 32;
    localparam int ADDRESS_WIDTH  = 16;
    localparam int CNT_W          = $clog2(MAX_DATA_BYTES + 1);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        IF_UNDEFINED = 3'd0,
        IF_I2C       = 3'd1,
        IF_SPI       = 3'd2,
        IF_UART      = 3'd3,
        IF_GPIO      = 3'd4
    } iface_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISSING  = 2'd1,
        ST_BADHEX   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_command;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [4:0]  byte_index;
        logic [2:0]  interface_type;
        logic        is_write;
        logic [15:0] device_address;
        logic [15:0] register_address;
        logic [5:0]  data_length;
        logic [1:0]  status;
        logic        last;
    } out_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data_byte;
        logic [4:0]  byte_index;
        logic        has_summary;
        logic [2:0]  interface_type;
        logic        is_write;
        logic [15:0] device_address;
        logic [15:0] register_address;
        logic [5:0]  data_length;
        logic [1:0]  status;
    } event_t;

endpackage

@@ rtl/bridge_command_line_parser.sv @@
// Top level of the bridge command line parser: front end, event queue, back end.
// Depends on bcl_pkg, bcl_front, bcl_queue and bcl_back.
//
// The parser takes one command character per cycle while the output side keeps up.
// Each character is parsed in the cycle it is accepted and leaves at most one event
// in a four-entry queue; the back end turns each event into one result item per cycle
// while res_stall is low, or two (a data byte, then the summary) when the final
// character also completes a data byte. Each result passes through the queue and the
// output register, and cmd_stall rises only when the queue is full.
module bridge_command_line_parser
    import bcl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  in_t  cmd,
    output logic res_valid,
    input  logic res_stall,
    output out_t res
);

    event_t ev;
    event_t head;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;

    assign cmd_stall = full;

    bcl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (cmd_valid && !full),
        .item   (cmd),
        .push   (push),
        .ev     (ev)
    );

    bcl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (ev),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    bcl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

@@ rtl/bcl_front.sv @@
// Front end: folds, splits and parses characters and builds at most one event per item.
// Depends on bcl_pkg.
module bcl_front
    import bcl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   accept,
    input  in_t    item,
    output logic   push,
    output event_t ev
);

    logic [2:0]               field_reg, field_next;
    logic                     inside_reg, inside_next;
    logic [7:0]               kw_reg [5];
    logic [7:0]               kw_next [5];
    logic [2:0]               kw_len_reg, kw_len_next;
    logic [7:0]               act_char_reg, act_char_next;
    logic [1:0]               act_len_reg, act_len_next;
    logic [ADDRESS_WIDTH-1:0] addr_reg, addr_next;
    logic [ADDRESS_WIDTH-1:0] regad_reg, regad_next;
    logic [4:0]               pend_reg, pend_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [1:0]               err_reg, err_next;

    logic [7:0]  c;
    logic        delim;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        emit_byte;
    logic [3:0]  fields;
    logic [2:0]  iface;
    logic [31:0] addr_ext;
    logic [31:0] regad_ext;
    logic [31:0] cnt_ext;

    always_comb
    begin
        c = item.char_in;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            c = c + 8'd32;
        end
        delim = (c == 8'h3B) || (c == 8'h2C);
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hex_ok  = 1'b1;
            hex_val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            hex_ok  = 1'b1;
            hex_val = 4'(c - 8'h57);
        end
    end

    always_comb
    begin
        field_next    = field_reg;
        inside_next   = inside_reg;
        kw_next       = kw_reg;
        kw_len_next   = kw_len_reg;
        act_char_next = act_char_reg;
        act_len_next  = act_len_reg;
        addr_next     = addr_reg;
        regad_next    = regad_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        emit_byte     = 1'b0;
        if (delim)
        begin
            if (inside_reg)
            begin
                inside_next = 1'b0;
                if (field_reg < 3'd5)
                begin
                    field_next = field_reg + 3'd1;
                end
            end
        end
        else
        begin
            inside_next = 1'b1;
            case (field_reg)
                3'd0:
                begin
                    if (kw_len_reg < 3'd5)
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            if (kw_len_reg == 3'(i))
                            begin
                                kw_next[i] = c;
                            end
                        end
                        kw_len_next = kw_len_reg + 3'd1;
                    end
                end
                3'd1:
                begin
                    if (act_len_reg == 2'd0)
                    begin
                        act_char_next = c;
                    end
                    if (act_len_reg < 2'd2)
                    begin
                        act_len_next = act_len_reg + 2'd1;
                    end
                end
                3'd2, 3'd3:
                begin
                    if (!hex_ok)
                    begin
                        if (err_reg == ST_OK)
                        begin
                            err_next = ST_BADHEX;
                        end
                    end
                    else if (field_reg == 3'd2)
                    begin
                        addr_next = {addr_reg[ADDRESS_WIDTH-5:0], hex_val};
                    end
                    else
                    begin
                        regad_next = {regad_reg[ADDRESS_WIDTH-5:0], hex_val};
                    end
                end
                3'd4:
                begin
                    if (!hex_ok)
                    begin
                        if (err_reg == ST_OK)
                        begin
                            err_next = ST_BADHEX;
                        end
                    end
                    else if (pend_reg[4])
                    begin
                        pend_next = 5'd0;
                        if (cnt_reg < CNT_W'(MAX_DATA_BYTES))
                        begin
                            emit_byte = 1'b1;
                            cnt_next  = cnt_reg + CNT_W'(1);
                        end
                        else if (err_reg == ST_OK)
                        begin
                            err_next = ST_OVERFLOW;
                        end
                    end
                    else
                    begin
                        pend_next = {1'b1, hex_val};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        iface = IF_UNDEFINED;
        if (kw_len_next == 3'd3 && kw_next[0] == 8'h69 && kw_next[1] == 8'h32
            && kw_next[2] == 8'h63)
        begin
            iface = IF_I2C;
        end
        else if (kw_len_next == 3'd3 && kw_next[0] == 8'h73 && kw_next[1] == 8'h70
            && kw_next[2] == 8'h69)
        begin
            iface = IF_SPI;
        end
        else if (kw_len_next == 3'd4 && kw_next[0] == 8'h75 && kw_next[1] == 8'h61
            && kw_next[2] == 8'h72 && kw_next[3] == 8'h74)
        begin
            iface = IF_UART;
        end
        else if (kw_len_next == 3'd4 && kw_next[0] == 8'h67 && kw_next[1] == 8'h70
            && kw_next[2] == 8'h69 && kw_next[3] == 8'h6F)
        begin
            iface = IF_GPIO;
        end
        fields    = {1'b0, field_next} + {3'd0, inside_next};
        addr_ext  = 32'(addr_next);
        regad_ext = 32'(regad_next);
        cnt_ext   = 32'(cnt_next);

        ev.has_byte         = emit_byte;
        ev.data_byte        = {pend_reg[3:0], hex_val};
        ev.byte_index       = 32'(cnt_reg) > 0 ? cnt_ext[4:0] - 5'd1 : 5'd0;
        ev.has_summary      = item.end_of_command;
        ev.interface_type   = iface;
        ev.is_write         = (act_len_next == 2'd1) && (act_char_next == 8'h77);
        ev.device_address   = addr_ext[15:0];
        ev.register_address = regad_ext[15:0];
        ev.data_length      = cnt_ext[5:0];
        ev.status           = (fields < 4'd5) ? ST_MISSING : err_next;
        push                = accept && (emit_byte || item.end_of_command);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg    <= 3'd0;
            inside_reg   <= 1'b0;
            kw_len_reg   <= 3'd0;
            act_char_reg <= 8'd0;
            act_len_reg  <= 2'd0;
            addr_reg     <= '0;
            regad_reg    <= '0;
            pend_reg     <= 5'd0;
            cnt_reg      <= '0;
            err_reg      <= ST_OK;
            for (int i = 0; i < 5; i++)
            begin
                kw_reg[i] <= 8'd0;
            end
        end
        else if (accept)
        begin
            if (item.end_of_command)
            begin
                field_reg    <= 3'd0;
                inside_reg   <= 1'b0;
                kw_len_reg   <= 3'd0;
                act_char_reg <= 8'd0;
                act_len_reg  <= 2'd0;
                addr_reg     <= '0;
                regad_reg    <= '0;
                pend_reg     <= 5'd0;
                cnt_reg      <= '0;
                err_reg      <= ST_OK;
                for (int i = 0; i < 5; i++)
                begin
                    kw_reg[i] <= 8'd0;
                end
            end
            else
            begin
                field_reg    <= field_next;
                inside_reg   <= inside_next;
                kw_reg       <= kw_next;
                kw_len_reg   <= kw_len_next;
                act_char_reg <= act_char_next;
                act_len_reg  <= act_len_next;
                addr_reg     <= addr_next;
                regad_reg    <= regad_next;
                pend_reg     <= pend_next;
                cnt_reg      <= cnt_next;
                err_reg      <= err_next;
            end
        end
    end

endmodule

@@ rtl/bcl_queue.sv @@
// Short event queue between the parser front end and the result sequencer.
// Depends on bcl_pkg.
module bcl_queue
    import bcl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_data,
    input  logic   pop,
    output event_t head,
    output logic   empty,
    output logic   full
);

    event_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        empty      = (count_reg == '0);
        full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
        head       = mem_reg[rd_reg];
        wr_next    = push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next    = pop ? rd_reg + QPTR_W'(1) : rd_reg;
        count_next = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/bcl_back.sv @@
// Back end: turns queued events into one or two result items in an output register.
// Depends on bcl_pkg.
module bcl_back
    import bcl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  event_t head,
    input  logic   empty,
    output logic   pop,
    input  logic   res_stall,
    output logic   res_valid,
    output out_t   res
);

    logic out_valid_reg, out_valid_next;
    out_t out_reg, out_next;
    logic byte_done_reg, byte_done_next;
    logic load;

    always_comb
    begin
        load           = !out_valid_reg || !res_stall;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        byte_done_next = byte_done_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !empty;
            out_next       = '0;
            if (!empty)
            begin
                if (head.has_byte && !byte_done_reg)
                begin
                    out_next.result_kind = KIND_BYTE;
                    out_next.data_byte   = head.data_byte;
                    out_next.byte_index  = head.byte_index;
                    out_next.last        = !head.has_summary;
                    pop                  = !head.has_summary;
                    byte_done_next       = head.has_summary;
                end
                else
                begin
                    out_next.result_kind      = KIND_SUMMARY;
                    out_next.interface_type   = head.interface_type;
                    out_next.is_write         = head.is_write;
                    out_next.device_address   = head.device_address;
                    out_next.register_address = head.register_address;
                    out_next.data_length      = head.data_length;
                    out_next.status           = head.status;
                    out_next.last             = 1'b1;
                    pop                       = 1'b1;
                    byte_done_next            = 1'b0;
                end
            end
        end
        res_valid = out_valid_reg;
        res       = out_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            byte_done_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            byte_done_reg <= byte_done_next;
        end
    end

endmodule
